/* src/ppt_pkg.sv */
// ----------------------------------------------------------------------------
// ppt_pkg
// Shared constants, types and width helpers for the pose point transform.
// ----------------------------------------------------------------------------
package ppt_pkg;

    localparam int COORD_WIDTH     = 32;
    localparam int QUAT_FRAC_BITS  = 14;
    localparam int QUAT_WIDTH      = 16;
    localparam int OFFSET_WIDTH    = 32;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int LANE_STAGES     = 4;

    localparam logic signed [QUAT_WIDTH-1:0] QUAT_ONE_RESET = 16'sd16384;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_ORIENT_X,
        REG_ORIENT_Y,
        REG_ORIENT_Z,
        REG_ORIENT_W,
        REG_OFFSET_X,
        REG_OFFSET_Y,
        REG_OFFSET_Z
    } cfg_reg_t;

    typedef struct packed {
        logic signed [QUAT_WIDTH-1:0]   qx;
        logic signed [QUAT_WIDTH-1:0]   qy;
        logic signed [QUAT_WIDTH-1:0]   qz;
        logic signed [QUAT_WIDTH-1:0]   qw;
        logic signed [OFFSET_WIDTH-1:0] ox;
        logic signed [OFFSET_WIDTH-1:0] oy;
        logic signed [OFFSET_WIDTH-1:0] oz;
    } pose_t;

    function automatic int min_int(input int a, input int b);
        return (a < b) ? a : b;
    endfunction

    function automatic int max_int(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    // Intermediates are kept exact, but never wider than 64 bits.
    function automatic int cross_sum_width(input int cw);
        return min_int(cw + QUAT_WIDTH + 2, 64);
    endfunction

    function automatic int cross_width(input int cw, input int f);
        return cross_sum_width(cw) - f;
    endfunction

    function automatic int rot_prod_width(input int cw, input int f);
        return min_int(QUAT_WIDTH + cross_width(cw, f), 64);
    endfunction

    function automatic int rot_sum_width(input int cw, input int f);
        return min_int(QUAT_WIDTH + cross_width(cw, f) + 3, 64);
    endfunction

    function automatic int rot_width(input int cw, input int f);
        return rot_sum_width(cw, f) - f + 1;
    endfunction

    function automatic int out_sum_width(input int cw, input int f);
        return min_int(max_int(max_int(cw, rot_width(cw, f)), OFFSET_WIDTH) + 2, 64);
    endfunction

endpackage

/* src/ppt_cfg.sv */
// ----------------------------------------------------------------------------
// ppt_cfg
// Pose register file: orientation quaternion and translation.
// ----------------------------------------------------------------------------
module ppt_cfg (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ppt_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [ppt_pkg::OFFSET_WIDTH-1:0]     cfg_data,
    output ppt_pkg::pose_t                       pose
);
    import ppt_pkg::*;

    pose_t pose_reg;

    assign cfg_ready = 1'b1;
    assign pose      = pose_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pose_reg.qx <= '0;
            pose_reg.qy <= '0;
            pose_reg.qz <= '0;
            pose_reg.qw <= QUAT_ONE_RESET;
            pose_reg.ox <= '0;
            pose_reg.oy <= '0;
            pose_reg.oz <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ORIENT_X: pose_reg.qx <= cfg_data[QUAT_WIDTH-1:0];
                REG_ORIENT_Y: pose_reg.qy <= cfg_data[QUAT_WIDTH-1:0];
                REG_ORIENT_Z: pose_reg.qz <= cfg_data[QUAT_WIDTH-1:0];
                REG_ORIENT_W: pose_reg.qw <= cfg_data[QUAT_WIDTH-1:0];
                REG_OFFSET_X: pose_reg.ox <= cfg_data;
                REG_OFFSET_Y: pose_reg.oy <= cfg_data;
                REG_OFFSET_Z: pose_reg.oz <= cfg_data;
                default:      pose_reg    <= pose_reg;
            endcase
        end
    end

endmodule

/* src/ppt_lane.sv */
// ----------------------------------------------------------------------------
// ppt_lane
// One coordinate of the rotation: two cross-product stages, then offset,
// sum and clamp.
// ----------------------------------------------------------------------------
module ppt_lane #(
    parameter int COORD_WIDTH    = ppt_pkg::COORD_WIDTH,
    parameter int QUAT_FRAC_BITS = ppt_pkg::QUAT_FRAC_BITS
) (
    input  logic                                    clk,
    input  logic                                    en,
    input  logic signed [ppt_pkg::QUAT_WIDTH-1:0]   qa,
    input  logic signed [ppt_pkg::QUAT_WIDTH-1:0]   qb,
    input  logic signed [ppt_pkg::QUAT_WIDTH-1:0]   qw,
    input  logic signed [ppt_pkg::OFFSET_WIDTH-1:0] offset,
    input  logic signed [COORD_WIDTH-1:0]           pa,
    input  logic signed [COORD_WIDTH-1:0]           pb,
    input  logic signed [COORD_WIDTH-1:0]           pself,
    output logic signed [ppt_pkg::cross_width(COORD_WIDTH, QUAT_FRAC_BITS)-1:0] c_out,
    input  logic signed [ppt_pkg::cross_width(COORD_WIDTH, QUAT_FRAC_BITS)-1:0] ca_in,
    input  logic signed [ppt_pkg::cross_width(COORD_WIDTH, QUAT_FRAC_BITS)-1:0] cb_in,
    output logic signed [COORD_WIDTH-1:0]           coord,
    output logic                                    hit
);
    import ppt_pkg::*;

    localparam int CW   = COORD_WIDTH;
    localparam int F    = QUAT_FRAC_BITS;
    localparam int P1W  = QUAT_WIDTH + CW;
    localparam int S1W  = cross_sum_width(CW);
    localparam int CWC  = cross_width(CW, F);
    localparam int P2W  = rot_prod_width(CW, F);
    localparam int S2W  = rot_sum_width(CW, F);
    localparam int RW   = rot_width(CW, F);
    localparam int SW   = out_sum_width(CW, F);

    localparam logic signed [S1W-1:0] ROUND1  = {{(S1W-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
    localparam logic signed [S2W-1:0] ROUND2  = {{(S2W-F+1){1'b0}}, 1'b1, {(F-2){1'b0}}};
    localparam logic signed [SW-1:0]  SUM_HI  = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [SW-1:0]  SUM_LO  = ~SUM_HI;

    logic signed [P1W-1:0] p_a_reg;
    logic signed [P1W-1:0] p_b_reg;
    logic signed [CWC-1:0] c_reg;
    logic signed [P2W-1:0] m_w_reg;
    logic signed [P2W-1:0] m_a_reg;
    logic signed [P2W-1:0] m_b_reg;
    logic signed [RW-1:0]  r_reg;
    logic signed [CW-1:0]  v1_reg;
    logic signed [CW-1:0]  v2_reg;
    logic signed [CW-1:0]  v3_reg;
    logic signed [CW-1:0]  v4_reg;

    logic signed [S1W-1:0] s1;
    logic signed [S2W-1:0] s2;
    logic signed [SW-1:0]  sum;

    assign s1    = S1W'(p_a_reg) - S1W'(p_b_reg) + ROUND1;
    assign s2    = S2W'(m_w_reg) + S2W'(m_a_reg) - S2W'(m_b_reg) + ROUND2;
    assign sum   = SW'(v4_reg) + SW'(r_reg) + SW'(offset);
    assign c_out = c_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_a_reg <= P1W'(qa) * P1W'(pb);
            p_b_reg <= P1W'(qb) * P1W'(pa);
            v1_reg  <= pself;

            c_reg   <= CWC'(s1 >>> F);
            v2_reg  <= v1_reg;

            m_w_reg <= P2W'(qw) * P2W'(c_reg);
            m_a_reg <= P2W'(qa) * P2W'(cb_in);
            m_b_reg <= P2W'(qb) * P2W'(ca_in);
            v3_reg  <= v2_reg;

            r_reg   <= RW'(s2 >>> (F - 1));
            v4_reg  <= v3_reg;
        end
    end

    always_comb
    begin
        priority if (sum > SUM_HI)
        begin
            coord = SUM_HI[CW-1:0];
            hit   = 1'b1;
        end
        else if (sum < SUM_LO)
        begin
            coord = SUM_LO[CW-1:0];
            hit   = 1'b1;
        end
        else
        begin
            coord = sum[CW-1:0];
            hit   = 1'b0;
        end
    end

endmodule

/* src/ppt_merge.sv */
// ----------------------------------------------------------------------------
// ppt_merge
// Joins the three lane results and the clamp flags into the output word.
// ----------------------------------------------------------------------------
module ppt_merge #(
    parameter int COORD_WIDTH = ppt_pkg::COORD_WIDTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic [COORD_WIDTH-1:0]              coord_x,
    input  logic [COORD_WIDTH-1:0]              coord_y,
    input  logic [COORD_WIDTH-1:0]              coord_z,
    input  logic [2:0]                          hits,
    output logic                                m_tvalid,
    output logic [((3*COORD_WIDTH+7)/8)*8-1:0]  m_tdata,
    output logic [0:0]                          m_tuser
);
    import ppt_pkg::*;

    localparam int DATA_W = 3 * COORD_WIDTH;
    localparam int OUT_W  = ((3 * COORD_WIDTH + 7) / 8) * 8;

    logic              valid_reg;
    logic [DATA_W-1:0] data_reg;
    logic              sat_reg;

    assign m_tvalid   = valid_reg;
    assign m_tdata    = OUT_W'(data_reg);
    assign m_tuser[0] = sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= {coord_z, coord_y, coord_x};
            sat_reg  <= |hits;
        end
    end

endmodule

/* src/pose_point_transform.sv */
// ----------------------------------------------------------------------------
// pose_point_transform
// Rotates each point by the configured quaternion and adds the translation.
// ----------------------------------------------------------------------------
// Throughput is one point per cycle while the output is not stalled: three coordinate lanes of four
// registered stages each, plus the output register.
// The whole pipeline holds while the output word waits to be taken.
// Reset loads the identity pose and clears all valid flags.
module pose_point_transform #(
    parameter int COORD_WIDTH    = ppt_pkg::COORD_WIDTH,
    parameter int QUAT_FRAC_BITS = ppt_pkg::QUAT_FRAC_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // point_x, point_y, point_z
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]   s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // out_x, out_y, out_z
    output logic [((3*COORD_WIDTH+7)/8)*8-1:0]   m_tdata,
    // saturated
    output logic [0:0]                           m_tuser,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ppt_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [ppt_pkg::OFFSET_WIDTH-1:0]     cfg_data
);
    import ppt_pkg::*;

    localparam int CW  = COORD_WIDTH;
    localparam int CWC = cross_width(COORD_WIDTH, QUAT_FRAC_BITS);
    localparam logic [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] COORD_MIN = ~COORD_MAX;

    pose_t                  pose;
    logic                   en;
    logic [LANE_STAGES-1:0] vld_reg;
    logic signed [CW-1:0]   vx, vy, vz;
    logic signed [CWC-1:0]  c_x, c_y, c_z;
    logic [CW-1:0]          coord_x, coord_y, coord_z;
    logic [2:0]             hits;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;
    assign vx       = $signed(s_tdata[CW-1:0]);
    assign vy       = $signed(s_tdata[2*CW-1:CW]);
    assign vz       = $signed(s_tdata[3*CW-1:2*CW]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LANE_STAGES-2:0], s_tvalid};
        end
    end

    ppt_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pose      (pose)
    );

    ppt_lane #(
        .COORD_WIDTH    (COORD_WIDTH),
        .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
    ) u_lane_x (
        .clk    (clk),
        .en     (en),
        .qa     (pose.qy),
        .qb     (pose.qz),
        .qw     (pose.qw),
        .offset (pose.ox),
        .pa     (vy),
        .pb     (vz),
        .pself  (vx),
        .c_out  (c_x),
        .ca_in  (c_y),
        .cb_in  (c_z),
        .coord  (coord_x),
        .hit    (hits[0])
    );

    ppt_lane #(
        .COORD_WIDTH    (COORD_WIDTH),
        .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
    ) u_lane_y (
        .clk    (clk),
        .en     (en),
        .qa     (pose.qz),
        .qb     (pose.qx),
        .qw     (pose.qw),
        .offset (pose.oy),
        .pa     (vz),
        .pb     (vx),
        .pself  (vy),
        .c_out  (c_y),
        .ca_in  (c_z),
        .cb_in  (c_x),
        .coord  (coord_y),
        .hit    (hits[1])
    );

    ppt_lane #(
        .COORD_WIDTH    (COORD_WIDTH),
        .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
    ) u_lane_z (
        .clk    (clk),
        .en     (en),
        .qa     (pose.qx),
        .qb     (pose.qy),
        .qw     (pose.qw),
        .offset (pose.oz),
        .pa     (vx),
        .pb     (vy),
        .pself  (vz),
        .c_out  (c_z),
        .ca_in  (c_x),
        .cb_in  (c_y),
        .coord  (coord_z),
        .hit    (hits[2])
    );

    ppt_merge #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (vld_reg[LANE_STAGES-1]),
        .coord_x  (coord_x),
        .coord_y  (coord_y),
        .coord_z  (coord_z),
        .hits     (hits),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) ##1 s_tready ##1 s_tready ##1 s_tready ##1 s_tready
        |=> m_tvalid)
        else $error("accepted point did not reach the output in time");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(vld_reg[LANE_STAGES-1]))
        else $error("output word appeared without a point in the last stage");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> $stable(vld_reg))
        else $error("pipeline moved while the output word was stalled");

    a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |->
            (m_tdata[CW-1:0] == COORD_MAX || m_tdata[CW-1:0] == COORD_MIN ||
             m_tdata[2*CW-1:CW] == COORD_MAX || m_tdata[2*CW-1:CW] == COORD_MIN ||
             m_tdata[3*CW-1:2*CW] == COORD_MAX || m_tdata[3*CW-1:2*CW] == COORD_MIN))
        else $error("saturation flag set with no coordinate at a bound");
`endif

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for pose_point_transform. Points stream in under random
// bursts and output back-pressure. A scoreboard predicts each rotated,
// translated and saturated result from its own copy of the pose and compares
// every output word in order. Pose registers are rewritten between phases
// while the pipeline is empty.
// ----------------------------------------------------------------------------
module testbench;
    import ppt_pkg::*;

    localparam int DATA_WIDTH    = ((3 * COORD_WIDTH + 7) / 8) * 8;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED = 3'd7;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASES        = 12;
    localparam int PHASE_POINTS  = 128;
    localparam int MAX_REPORTS   = 100;
    localparam int COORD_MAX     = 32'sh7fff_ffff;
    localparam int COORD_MIN     = 32'sh8000_0000;
    localparam int QUAT_MAX      = 32767;
    localparam int QUAT_MIN      = -32768;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] z;
        logic signed [COORD_WIDTH-1:0] y;
        logic signed [COORD_WIDTH-1:0] x;
    } point_t;

    typedef struct {
        point_t coords;
        logic   saturated;
    } result_t;

    typedef enum {STALL_NONE, STALL_RANDOM, STALL_PATTERN, STALL_LONG} stall_kind_t;
    typedef enum {VALUE_SMALL, VALUE_FULL, VALUE_EXTREME} value_kind_t;

    class transform_scoreboard;
        pose_t   pose;
        result_t expected_words[$];
        int      errors;
        int      reports;
        int      points;
        int      words;
        int      clamped;

        function new();
            pose = '0;
            pose.qw = QUAT_ONE_RESET;
        endfunction

        function void write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                                input logic [OFFSET_WIDTH-1:0] data);
            case (idx)
                REG_ORIENT_X: pose.qx = data[QUAT_WIDTH-1:0];
                REG_ORIENT_Y: pose.qy = data[QUAT_WIDTH-1:0];
                REG_ORIENT_Z: pose.qz = data[QUAT_WIDTH-1:0];
                REG_ORIENT_W: pose.qw = data[QUAT_WIDTH-1:0];
                REG_OFFSET_X: pose.ox = data;
                REG_OFFSET_Y: pose.oy = data;
                REG_OFFSET_Z: pose.oz = data;
                default: ;
            endcase
        endfunction

        function longint rounded_shift(input longint value, input int sh);
            return (value + (longint'(1) <<< (sh - 1))) >>> sh;
        endfunction

        function logic signed [COORD_WIDTH-1:0] clamp_coord(input longint sum,
                                                            inout logic hit);
            longint hi;
            longint lo;
            hi = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
            lo = -hi - 1;
            if (sum > hi)
            begin
                hit = 1'b1;
                return hi[COORD_WIDTH-1:0];
            end
            if (sum < lo)
            begin
                hit = 1'b1;
                return lo[COORD_WIDTH-1:0];
            end
            return sum[COORD_WIDTH-1:0];
        endfunction

        // Rotation is v + 2w(u x v) + 2(u x (u x v)); the cross product is
        // rounded back to coordinate format before the second one is taken.
        function result_t rotate_translate(input point_t p);
            longint vx, vy, vz, ux, uy, uz, w;
            longint cx, cy, cz, dx, dy, dz, rx, ry, rz;
            result_t r;
            vx = longint'(p.x);
            vy = longint'(p.y);
            vz = longint'(p.z);
            ux = longint'(pose.qx);
            uy = longint'(pose.qy);
            uz = longint'(pose.qz);
            w  = longint'(pose.qw);
            cx = rounded_shift(uy * vz - uz * vy, QUAT_FRAC_BITS);
            cy = rounded_shift(uz * vx - ux * vz, QUAT_FRAC_BITS);
            cz = rounded_shift(ux * vy - uy * vx, QUAT_FRAC_BITS);
            dx = uy * cz - uz * cy;
            dy = uz * cx - ux * cz;
            dz = ux * cy - uy * cx;
            rx = rounded_shift(w * cx + dx, QUAT_FRAC_BITS - 1);
            ry = rounded_shift(w * cy + dy, QUAT_FRAC_BITS - 1);
            rz = rounded_shift(w * cz + dz, QUAT_FRAC_BITS - 1);
            r.saturated = 1'b0;
            r.coords.x = clamp_coord(vx + rx + longint'(pose.ox), r.saturated);
            r.coords.y = clamp_coord(vy + ry + longint'(pose.oy), r.saturated);
            r.coords.z = clamp_coord(vz + rz + longint'(pose.oz), r.saturated);
            return r;
        endfunction

        function void add_point(input point_t p);
            points++;
            expected_words.push_back(rotate_translate(p));
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        function void compare_field(input string name,
                                    input logic signed [COORD_WIDTH-1:0] want,
                                    input logic signed [COORD_WIDTH-1:0] got);
            if (got !== want)
            begin
                errors++;
                if (reports < MAX_REPORTS)
                begin
                    reports++;
                    $display("%0t  %s mismatch: expected %0d, actual %0d",
                             $time, name, want, got);
                end
            end
        endfunction

        function void check_word(input point_t got, input logic sat);
            result_t want;
            if (expected_words.size() == 0)
            begin
                errors++;
                if (reports < MAX_REPORTS)
                begin
                    reports++;
                    $display("%0t  unexpected word: expected none, actual %0d %0d %0d sat %b",
                             $time, got.x, got.y, got.z, sat);
                end
                return;
            end
            want = expected_words.pop_front();
            words++;
            if (want.saturated)
                clamped++;
            compare_field("out_x", want.coords.x, got.x);
            compare_field("out_y", want.coords.y, got.y);
            compare_field("out_z", want.coords.z, got.z);
            compare_field("saturated", COORD_WIDTH'(want.saturated), COORD_WIDTH'(sat));
        endfunction
    endclass

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       s_tvalid  = 1'b0;
    logic                       s_tready;
    logic [DATA_WIDTH-1:0]      s_tdata   = '0;
    logic                       m_tvalid;
    logic                       m_tready  = 1'b0;
    logic [DATA_WIDTH-1:0]      m_tdata;
    logic [0:0]                 m_tuser;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [OFFSET_WIDTH-1:0]    cfg_data  = '0;

    stall_kind_t stall_mode = STALL_NONE;
    int          stall_pct  = 0;
    logic [15:0] stall_mask = 16'hffff;
    logic [3:0]  stall_tick = '0;
    int          hold_count = 0;
    bit          bursty     = 1'b0;
    int          burst_left = 0;

    transform_scoreboard board = new();

    pose_point_transform dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            board.add_point(s_tdata);
        if (rst_n && m_tvalid && m_tready)
            board.check_word(m_tdata, m_tuser[0]);
    end

    always @(posedge clk)
    begin
        stall_tick <= stall_tick + 1'b1;
        if (stall_mode != STALL_LONG)
            hold_count <= 0;
        case (stall_mode)
            STALL_NONE:    m_tready <= 1'b1;
            STALL_RANDOM:  m_tready <= ($urandom_range(0, 99) >= stall_pct);
            STALL_PATTERN: m_tready <= stall_mask[stall_tick];
            STALL_LONG:
            begin
                if (hold_count < HOLD_CYCLES)
                begin
                    m_tready <= 1'b0;
                    hold_count <= hold_count + 1;
                end
                else
                begin
                    m_tready <= 1'b1;
                end
            end
        endcase
    end

    function automatic int extreme_coord();
        case ($urandom_range(0, 4))
            0:       return COORD_MIN;
            1:       return COORD_MAX;
            2:       return 0;
            3:       return -1;
            default: return 1;
        endcase
    endfunction

    function automatic int extreme_quat();
        case ($urandom_range(0, 3))
            0:       return QUAT_MIN;
            1:       return QUAT_MAX;
            2:       return 0;
            default: return int'(QUAT_ONE_RESET);
        endcase
    endfunction

    function automatic point_t make_point(input int x, input int y, input int z);
        point_t p;
        p.x = x;
        p.y = y;
        p.z = z;
        return p;
    endfunction

    function automatic pose_t make_pose(input int qx, input int qy, input int qz,
                                        input int qw, input int ox, input int oy,
                                        input int oz);
        pose_t p;
        p.qx = QUAT_WIDTH'(qx);
        p.qy = QUAT_WIDTH'(qy);
        p.qz = QUAT_WIDTH'(qz);
        p.qw = QUAT_WIDTH'(qw);
        p.ox = ox;
        p.oy = oy;
        p.oz = oz;
        return p;
    endfunction

    function automatic point_t random_point(input value_kind_t kind);
        case (kind)
            VALUE_SMALL:
                return make_point(int'($urandom_range(0, 1 << 21)) - (1 << 20),
                                  int'($urandom_range(0, 1 << 21)) - (1 << 20),
                                  int'($urandom_range(0, 1 << 21)) - (1 << 20));
            VALUE_FULL:
                return make_point($urandom(), $urandom(), $urandom());
            default:
                return make_point(extreme_coord(), extreme_coord(), extreme_coord());
        endcase
    endfunction

    function automatic pose_t random_pose(input value_kind_t kind);
        case (kind)
            VALUE_SMALL:
                return make_pose(int'($urandom_range(0, 32768)) - 16384,
                                 int'($urandom_range(0, 32768)) - 16384,
                                 int'($urandom_range(0, 32768)) - 16384,
                                 int'($urandom_range(0, 32768)) - 16384,
                                 int'($urandom_range(0, 1 << 25)) - (1 << 24),
                                 int'($urandom_range(0, 1 << 25)) - (1 << 24),
                                 int'($urandom_range(0, 1 << 25)) - (1 << 24));
            VALUE_FULL:
                return make_pose($urandom(), $urandom(), $urandom(), $urandom(),
                                 $urandom(), $urandom(), $urandom());
            default:
                return make_pose(extreme_quat(), extreme_quat(), extreme_quat(),
                                 extreme_quat(), extreme_coord(), extreme_coord(),
                                 extreme_coord());
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                             input logic [OFFSET_WIDTH-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.write_reg(idx, data);
    endtask

    // The upper half of a quaternion write carries junk that must be dropped.
    task automatic load_pose(input pose_t p);
        write_reg(REG_ORIENT_X, {16'($urandom()), p.qx});
        write_reg(REG_ORIENT_Y, {16'($urandom()), p.qy});
        write_reg(REG_ORIENT_Z, {16'($urandom()), p.qz});
        write_reg(REG_ORIENT_W, {16'($urandom()), p.qw});
        write_reg(REG_OFFSET_X, p.ox);
        write_reg(REG_OFFSET_Y, p.oy);
        write_reg(REG_OFFSET_Z, p.oz);
        write_reg(REG_UNUSED, $urandom());
        cfg_valid <= 1'b0;
    endtask

    task automatic stream_point(input point_t p);
        s_tdata  <= p;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (bursty)
        begin
            if (burst_left > 0)
            begin
                burst_left--;
            end
            else
            begin
                burst_left = $urandom_range(0, 15);
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        point_t      corners [6];
        pose_t       directed [3];
        value_kind_t kind;
        int          roll;

        corners[0] = make_point(COORD_MAX, COORD_MAX, COORD_MAX);
        corners[1] = make_point(COORD_MIN, COORD_MIN, COORD_MIN);
        corners[2] = make_point(COORD_MAX, COORD_MIN, 0);
        corners[3] = make_point(0, 0, 0);
        corners[4] = make_point(1, -1, 32'sh0000_8000);
        corners[5] = make_point(COORD_MIN, COORD_MAX, -1);
        // A quarter turn about z, then unnormalized quaternions at both extremes.
        directed[0] = make_pose(0, 0, 11585, 11585, 32'sh0001_8000, -32'sh0002_4000,
                                COORD_MAX);
        directed[1] = make_pose(QUAT_MIN, QUAT_MIN, QUAT_MIN, QUAT_MIN,
                                COORD_MIN, COORD_MIN, COORD_MIN);
        directed[2] = make_pose(QUAT_MAX, QUAT_MAX, QUAT_MAX, QUAT_MAX,
                                COORD_MAX, COORD_MAX, COORD_MAX);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        stall_mask <= 16'h5b6d;
        stall_mode <= STALL_PATTERN;
        bursty = 1'b1;
        for (int k = 0; k < 4; k++)
        begin
            if (k > 0)
                load_pose(directed[k-1]);
            foreach (corners[i])
                stream_point(corners[i]);
            settle();
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            load_pose(random_pose(value_kind_t'(ph % 3)));
            if (ph == 0)
            begin
                stall_mode <= STALL_NONE;
                bursty = 1'b0;
            end
            else if (ph == 3)
            begin
                stall_mode <= STALL_LONG;
                bursty = 1'b0;
            end
            else
            begin
                if ($urandom_range(0, 1) != 0)
                    stall_mode <= STALL_RANDOM;
                else
                    stall_mode <= STALL_PATTERN;
                stall_pct  <= $urandom_range(10, 70);
                stall_mask <= 16'($urandom()) | 16'h0001;
                bursty = ($urandom_range(0, 2) != 0);
            end
            for (int n = 0; n < PHASE_POINTS; n++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 50)
                    kind = VALUE_SMALL;
                else if (roll < 85)
                    kind = VALUE_FULL;
                else
                    kind = VALUE_EXTREME;
                stream_point(random_point(kind));
            end
            settle();
        end

        $display("Streamed %0d points under %0d pose settings,", board.points, PHASES + 4);
        $display("with bursts, stalls and a %0d-cycle output hold; checked %0d words, %0d saturated.",
                 HOLD_CYCLES, board.words, board.clamped);
        if (board.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #6_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
